// ----- rtl/core/bdb_pkg.sv -----
// Shared types and constants of the byte device bank.
`default_nettype none

package bdb_pkg;

    localparam int CMD_W       = 2;
    localparam int ADDR_W      = 5;
    localparam int DATA_W      = 8;
    localparam int DEV_W       = 4;
    localparam int ELAPSED_W   = 16;
    localparam int DUR_W       = 16;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 64;

    localparam int DEVS_PER_GROUP = 4;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // status byte layout
    localparam int STAT_IE_POS  = 0;
    localparam int STAT_DA_POS  = 2;
    localparam int STAT_OVF_POS = 3;

    localparam logic [DATA_W-1:0] IE_BIT = 8'h01;

    typedef enum logic [CMD_W-1:0] {
        CMD_READ   = 2'd0,
        CMD_WRITE  = 2'd1,
        CMD_TICK   = 2'd2,
        CMD_ARRIVE = 2'd3
    } t_cmd;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_DIRECTION = 3'd0,
        CFG_TIME_A    = 3'd1,
        CFG_TIME_B    = 3'd2,
        CFG_TIME_C    = 3'd3,
        CFG_TIME_D    = 3'd4
    } t_cfg_reg;

    typedef struct packed {
        logic                   we;
        logic [CFG_INDEX_W-1:0] index;
        logic [CFG_DATA_W-1:0]  data;
    } t_cfg_wr;

    // classified item as it travels from front to back
    typedef struct packed {
        t_cmd                 cmd;
        logic [DEV_W-1:0]     dev;
        logic                 is_status;
        logic                 dev_ok;
        logic [DATA_W-1:0]    data;
        logic [ELAPSED_W-1:0] elapsed;
        logic                 gie;
    } t_op;

    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic              irq_valid;
        logic [DEV_W-1:0]  irq_device;
        logic              last;
    } t_result;

endpackage

`default_nettype wire

// ----- rtl/core/bdb_in_if.sv -----
// Input item channel of the byte device bank.
`default_nettype none

interface bdb_in_if;
    import bdb_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CMD_W-1:0]     cmd;
    logic [ADDR_W-1:0]    address;
    logic [DATA_W-1:0]    write_data;
    logic [DEV_W-1:0]     arrival_device;
    logic [DATA_W-1:0]    arrival_byte;
    logic [ELAPSED_W-1:0] elapsed;
    logic                 global_enable;

    modport source (
        output valid, cmd, address, write_data, arrival_device, arrival_byte,
               elapsed, global_enable,
        input  ready
    );

    modport sink (
        input  valid, cmd, address, write_data, arrival_device, arrival_byte,
               elapsed, global_enable,
        output ready
    );
endinterface

`default_nettype wire

// ----- rtl/core/bdb_out_if.sv -----
// Result item channel of the byte device bank.
`default_nettype none

interface bdb_out_if;
    import bdb_pkg::*;

    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] read_data;
    logic              irq_valid;
    logic [DEV_W-1:0]  irq_device;
    logic              last;

    modport source (
        output valid, read_data, irq_valid, irq_device, last,
        input  ready
    );

    modport sink (
        input  valid, read_data, irq_valid, irq_device, last,
        output ready
    );
endinterface

`default_nettype wire

// ----- rtl/core/bdb_front.sv -----
// Front end: accepts input items and classifies them into queue entries.
`default_nettype none

module bdb_front #(
    parameter int DEVICE_COUNT = 16
) (
    bdb_in_if.sink         i_item,
    input  logic           i_full,
    output logic           o_push,
    output bdb_pkg::t_op   o_op
);
    import bdb_pkg::*;

    logic [DEV_W-1:0] dev;

    assign i_item.ready = !i_full;
    assign o_push       = i_item.valid && !i_full;

    always_comb begin
        o_op         = '0;
        o_op.cmd     = t_cmd'(i_item.cmd);
        o_op.elapsed = i_item.elapsed;
        o_op.gie     = i_item.global_enable;
        case (t_cmd'(i_item.cmd))
            CMD_ARRIVE: begin
                dev            = i_item.arrival_device;
                o_op.data      = i_item.arrival_byte;
                o_op.is_status = 1'b0;
            end
            default: begin
                dev            = i_item.address[ADDR_W-1:1];
                o_op.data      = i_item.write_data;
                o_op.is_status = !i_item.address[0];
            end
        endcase
        o_op.dev    = dev;
        o_op.dev_ok = ({1'b0, dev} < (DEV_W + 1)'(DEVICE_COUNT));
    end

endmodule

`default_nettype wire

// ----- rtl/core/bdb_queue.sv -----
// Short queue of classified items between front and back.
`default_nettype none

module bdb_queue (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  bdb_pkg::t_op i_data,
    output logic         o_full,
    output logic         o_valid,
    output bdb_pkg::t_op o_data,
    input  logic         i_pop
);
    import bdb_pkg::*;

    t_op               r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wptr;
    logic [QPTR_W-1:0] r_rptr;
    logic [QCNT_W-1:0] r_count;

    function automatic logic [QPTR_W-1:0] f_next(input logic [QPTR_W-1:0] p);
        logic [QPTR_W-1:0] n;
        if (p == QPTR_W'(QUEUE_DEPTH - 1)) begin
            n = '0;
        end else begin
            n = p + QPTR_W'(1);
        end
        return n;
    endfunction

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= f_next(r_wptr);
            end
            if (i_pop) begin
                r_rptr <= f_next(r_rptr);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + QCNT_W'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - QCNT_W'(1);
            end
        end
    end

`ifndef SYNTHESIS
    a_no_overfill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_count != QCNT_W'(QUEUE_DEPTH)))
        else $error("queue push while full");
    a_no_underrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_count != '0))
        else $error("queue pop while empty");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count beyond depth");
`endif

endmodule

`default_nettype wire

// ----- rtl/core/bdb_back.sv -----
// Back end: device state, configuration registers and result register.
`default_nettype none

module bdb_back #(
    parameter int DEVICE_COUNT = 16,
    parameter int TIME_WIDTH   = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  bdb_pkg::t_cfg_wr i_cfg,
    input  bdb_pkg::t_op     i_op,
    input  logic             i_op_valid,
    output logic             o_pop,
    bdb_out_if.source        o_result
);
    import bdb_pkg::*;

    localparam int CMP_W = (TIME_WIDTH > ELAPSED_W) ? TIME_WIDTH : ELAPSED_W;

    // configuration
    logic [DEVICE_COUNT-1:0] r_dir;
    logic [TIME_WIDTH-1:0]   r_dur [DEVICE_COUNT];

    // device state
    logic [DEVICE_COUNT-1:0] r_ie,   n_ie;
    logic [DEVICE_COUNT-1:0] r_da,   n_da;
    logic [DEVICE_COUNT-1:0] r_ovf,  n_ovf;
    logic [DEVICE_COUNT-1:0] r_busy, n_busy;
    logic [DATA_W-1:0]       r_data [DEVICE_COUNT];
    logic [DATA_W-1:0]       n_data [DEVICE_COUNT];
    logic [TIME_WIDTH-1:0]   r_tl   [DEVICE_COUNT];
    logic [TIME_WIDTH-1:0]   n_tl   [DEVICE_COUNT];

    // interrupts of a tick still to be sent
    logic [DEVICE_COUNT-1:0] r_pend, n_pend;

    t_result r_out, n_out;
    logic    r_out_valid, n_out_valid;

    logic                    can_load;
    logic                    emit_pend;
    logic                    exec;
    logic [DEVICE_COUNT-1:0] sel;
    logic [TIME_WIDTH-1:0]   tl_dec [DEVICE_COUNT];
    logic [DEVICE_COUNT-1:0] fin;
    logic [DEVICE_COUNT-1:0] tick_irq;
    logic [DEVICE_COUNT-1:0] pick_src;
    logic [DEVICE_COUNT-1:0] pick_first;
    logic [DEVICE_COUNT-1:0] pick_rest;
    logic [DEV_W-1:0]        pick_idx;

    assign can_load  = !r_out_valid || o_result.ready;
    assign emit_pend = can_load && (r_pend != '0);
    assign exec      = can_load && (r_pend == '0) && i_op_valid;
    assign o_pop     = exec;

    // per-device countdown and completion for a tick
    always_comb begin
        for (int d = 0; d < DEVICE_COUNT; d++) begin
            sel[d] = i_op.dev_ok && (i_op.dev == DEV_W'(d));
            if (CMP_W'(r_tl[d]) > CMP_W'(i_op.elapsed)) begin
                tl_dec[d] = TIME_WIDTH'(CMP_W'(r_tl[d]) - CMP_W'(i_op.elapsed));
            end else begin
                tl_dec[d] = '0;
            end
            fin[d]      = r_busy[d] && (tl_dec[d] == '0);
            tick_irq[d] = fin[d] && r_ie[d] && i_op.gie;
        end
    end

    // lowest interrupting device first
    always_comb begin
        pick_src   = emit_pend ? r_pend : tick_irq;
        pick_first = pick_src & (~pick_src + DEVICE_COUNT'(1));
        pick_rest  = pick_src & ~pick_first;
        pick_idx   = '0;
        for (int d = DEVICE_COUNT - 1; d >= 0; d--) begin
            if (pick_src[d]) begin
                pick_idx = DEV_W'(d);
            end
        end
    end

    always_comb begin
        n_ie        = r_ie;
        n_da        = r_da;
        n_ovf       = r_ovf;
        n_busy      = r_busy;
        n_data      = r_data;
        n_tl        = r_tl;
        n_pend      = r_pend;
        n_out       = r_out;
        n_out_valid = r_out_valid && !o_result.ready;

        if (emit_pend) begin
            n_out            = '0;
            n_out.irq_valid  = 1'b1;
            n_out.irq_device = pick_idx;
            n_out.last       = (pick_rest == '0);
            n_out_valid      = 1'b1;
            n_pend           = pick_rest;
        end else if (exec) begin
            n_out       = '0;
            n_out.last  = 1'b1;
            n_out_valid = 1'b1;
            case (i_op.cmd)
                CMD_READ: begin
                    for (int d = 0; d < DEVICE_COUNT; d++) begin
                        if (sel[d]) begin
                            if (i_op.is_status) begin
                                n_out.read_data[STAT_IE_POS]  = r_ie[d];
                                n_out.read_data[STAT_DA_POS]  = r_da[d];
                                n_out.read_data[STAT_OVF_POS] = r_ovf[d];
                            end else if (r_dir[d]) begin
                                n_out.read_data = r_data[d];
                                n_da[d]         = 1'b0;
                                n_ovf[d]        = 1'b0;
                            end
                        end
                    end
                end
                CMD_WRITE: begin
                    for (int d = 0; d < DEVICE_COUNT; d++) begin
                        if (sel[d]) begin
                            if (i_op.is_status) begin
                                n_ie[d] = ((i_op.data & IE_BIT) != '0);
                            end else if (!r_dir[d]) begin
                                if (r_da[d]) begin
                                    n_ovf[d] = 1'b1;
                                end
                                n_da[d]   = 1'b1;
                                n_data[d] = i_op.data;
                                n_tl[d]   = r_dur[d];
                                n_busy[d] = 1'b1;
                            end
                        end
                    end
                end
                CMD_ARRIVE: begin
                    for (int d = 0; d < DEVICE_COUNT; d++) begin
                        if (sel[d]) begin
                            if (r_da[d]) begin
                                n_ovf[d] = 1'b1;
                            end
                            n_da[d]   = 1'b1;
                            n_data[d] = i_op.data;
                            if (r_ie[d] && i_op.gie) begin
                                n_out.irq_valid  = 1'b1;
                                n_out.irq_device = i_op.dev;
                            end
                        end
                    end
                end
                CMD_TICK: begin
                    for (int d = 0; d < DEVICE_COUNT; d++) begin
                        if (r_busy[d]) begin
                            n_tl[d] = tl_dec[d];
                        end
                        if (fin[d]) begin
                            n_da[d]   = 1'b0;
                            n_busy[d] = 1'b0;
                        end
                        if (tick_irq[d]) begin
                            n_ie[d] = 1'b0;
                        end
                    end
                    // send the first interrupt now, hold the rest
                    if (tick_irq != '0) begin
                        n_out.irq_valid  = 1'b1;
                        n_out.irq_device = pick_idx;
                        n_out.last       = (pick_rest == '0);
                        n_pend           = pick_rest;
                    end
                end
                default: begin
                    n_out_valid = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dir <= '0;
            for (int d = 0; d < DEVICE_COUNT; d++) begin
                r_dur[d] <= '0;
            end
        end else if (i_cfg.we) begin
            if (i_cfg.index == CFG_DIRECTION) begin
                r_dir <= i_cfg.data[DEVICE_COUNT-1:0];
            end
            for (int d = 0; d < DEVICE_COUNT; d++) begin
                if (i_cfg.index == CFG_INDEX_W'(CFG_TIME_A + d / DEVS_PER_GROUP)) begin
                    r_dur[d] <= TIME_WIDTH'(
                        i_cfg.data[DUR_W * (d % DEVS_PER_GROUP) +: DUR_W]);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ie        <= '0;
            r_da        <= '0;
            r_ovf       <= '0;
            r_busy      <= '0;
            r_pend      <= '0;
            r_out_valid <= 1'b0;
            for (int d = 0; d < DEVICE_COUNT; d++) begin
                r_data[d] <= '0;
                r_tl[d]   <= '0;
            end
        end else begin
            r_ie        <= n_ie;
            r_da        <= n_da;
            r_ovf       <= n_ovf;
            r_busy      <= n_busy;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
            r_data      <= n_data;
            r_tl        <= n_tl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_result.valid      = r_out_valid;
    assign o_result.read_data  = r_out.read_data;
    assign o_result.irq_valid  = r_out.irq_valid;
    assign o_result.irq_device = r_out.irq_device;
    assign o_result.last       = r_out.last;

`ifndef SYNTHESIS
    a_pend_has_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend != '0) |-> r_out_valid)
        else $error("pending interrupts without a result on the output");
    a_not_last_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.last) |-> (r_pend != '0))
        else $error("result not marked last but nothing left to send");
    a_quiet_dev_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.irq_valid) |-> (r_out.irq_device == '0))
        else $error("device number on a result without interrupt");
`endif

endmodule

`default_nettype wire

// ----- rtl/core/byte_device_bank_with_interrupts.sv -----
// Top level of the byte device bank with interrupts.
`default_nettype none

// Bank of up to 16 byte devices on a 32-address bus (even address status,
// odd address data) with per-device output timers and interrupt requests.
// Items enter a two-entry queue after classification; the back end executes
// one queued item per cycle whenever its output register is free or being
// taken. Bus reads, bus writes and arrivals give one result each; a tick
// gives one result per device that finishes with an interrupt (at least
// one), emitted in rising device order, and the back end takes no new item
// until the last of those results is loaded. An accepted item is registered
// in the queue and its result in the output register. Configuration writes
// take effect on the edge they are presented; the user must make them only
// while idle, and the block itself does not enforce this.
module byte_device_bank_with_interrupts #(
    parameter int DEVICE_COUNT = 16,
    parameter int TIME_WIDTH   = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    bdb_in_if.sink                          i_item,
    bdb_out_if.source                       o_result,
    input  logic                            i_cfg_we,
    input  logic [bdb_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [bdb_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import bdb_pkg::*;

    t_cfg_wr cfg;
    t_op     push_op;
    t_op     head_op;
    logic    push;
    logic    full;
    logic    head_valid;
    logic    pop;

    assign cfg.we    = i_cfg_we;
    assign cfg.index = i_cfg_index;
    assign cfg.data  = i_cfg_data;

    bdb_front #(
        .DEVICE_COUNT (DEVICE_COUNT)
    ) u_front (
        .i_item (i_item),
        .i_full (full),
        .o_push (push),
        .o_op   (push_op)
    );

    bdb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_op),
        .o_full  (full),
        .o_valid (head_valid),
        .o_data  (head_op),
        .i_pop   (pop)
    );

    bdb_back #(
        .DEVICE_COUNT (DEVICE_COUNT),
        .TIME_WIDTH   (TIME_WIDTH)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_op       (head_op),
        .i_op_valid (head_valid),
        .o_pop      (pop),
        .o_result   (o_result)
    );

endmodule

`default_nettype wire
